FILE: hw/rtl/all_pairs_shortest_path_assert.svh
// assertion macros shared by the shortest path block
// every macro samples on i_clk and is held off while i_rst_n is low
`ifndef ALL_PAIRS_SHORTEST_PATH_ASSERT_SVH
`define ALL_PAIRS_SHORTEST_PATH_ASSERT_SVH

// same-cycle implication
`define APSP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define APSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// condition that never holds
`define APSP_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

FILE: hw/rtl/apsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsp_pkg
// Shared widths, codes, state types and helpers of the shortest path block.
// ----------------------------------------------------------------------------
package apsp_pkg;

    // build-time default
    localparam int DEF_MAX_VERTICES = 16;

    // field widths
    localparam int IDX_W      = 4;
    localparam int WEIGHT_W   = 16;
    localparam int VIA_W      = 5;
    localparam int VC_W       = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 24;
    localparam int M_TUSER_W  = 1;

    // register reset values
    localparam logic [VC_W-1:0]     VC_RESET      = 5'd16;
    localparam logic [WEIGHT_W-1:0] NO_EDGE_RESET = 16'd1000;

    // command codes
    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_QUERY = 2'd2
    } t_cmd;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VERTEX_COUNT = 1'b0,
        CFG_NO_EDGE      = 1'b1
    } t_cfg_idx;

    // front-end control
    typedef enum logic [1:0] {
        TOP_IDLE,
        TOP_RUN,
        TOP_ACK
    } t_top_state;

    // run sequencer
    typedef enum logic [2:0] {
        ENG_IDLE,
        ENG_SWEEP,
        ENG_SWEEP_TAIL,
        ENG_IK,
        ENG_IK_CHECK,
        ENG_ROW,
        ENG_DONE
    } t_eng_state;

    // host side request into the memory engine
    typedef struct packed {
        logic                ld_en;
        logic                q_en;
        logic                run;
        logic [IDX_W-1:0]    row;
        logic [IDX_W-1:0]    col;
        logic [WEIGHT_W-1:0] weight;
    } t_host_req;

    // a leg joins a path only when it is nonzero and below the no-edge value
    function automatic logic usable_leg(input logic [WEIGHT_W-1:0] w,
                                        input logic [WEIGHT_W-1:0] no_edge);
        return (w != '0) && (w < no_edge);
    endfunction

endpackage

FILE: hw/rtl/all_pairs_shortest_path.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// all_pairs_shortest_path
// Floyd-Warshall engine: edge loads, a full run, and pair queries.
// ----------------------------------------------------------------------------
// Usage
//   Input beats on the s_axis group carry load, run and query commands.
//   Run and query each give one result beat on m_axis; loads give none.
//   Loads and queries are taken one per cycle while results drain. A query
//   answer reaches o_m_axis_tvalid through the distance/via memory read
//   register, loaded when its beat is accepted, and then the output
//   register, which loads once the output is free.
//   A run copies active-block weights into the distance store and clears the
//   whole via store in one sweep of S*S entries (S = MAX_VERTICES rounded up
//   to a power of two), then walks k and i over the active vertices: it reads
//   and checks d[i][k] and, when usable, runs j through the relax pipe; the
//   acknowledge follows the last write. No input beat is taken meanwhile.
//   Reset clears the control state and sets vertex_count to 16 and the
//   no-edge value to 1000; store contents are undefined until loaded or run.
//   When the receiver stalls, the result is held in the output register and
//   one more query can sit in the memory read stage; then input stalls.
// ----------------------------------------------------------------------------
`include "all_pairs_shortest_path_assert.svh"

module all_pairs_shortest_path #(
    parameter int MAX_VERTICES = apsp_pkg::DEF_MAX_VERTICES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command, row, col, weight
    input  logic [apsp_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // distance, reachable, via_vertex
    output logic [apsp_pkg::M_TDATA_W-1:0]  o_m_axis_tdata,
    // is_query_answer
    output logic [apsp_pkg::M_TUSER_W-1:0]  o_m_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    input  logic                            i_cfg_we,
    input  logic [apsp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [apsp_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int WW = apsp_pkg::WEIGHT_W;
    localparam int XW = apsp_pkg::VIA_W;
    localparam int IW = apsp_pkg::IDX_W;

    apsp_pkg::t_top_state r_state, n_state;

    logic [apsp_pkg::VC_W-1:0]      r_vertex_count;
    logic [WW-1:0]                  r_no_edge;
    logic                           r_q_pend;
    logic                           r_q_oob;
    logic                           r_out_valid;
    logic [apsp_pkg::M_TDATA_W-1:0] r_out_data;
    logic [apsp_pkg::M_TUSER_W-1:0] r_out_user;

    apsp_pkg::t_cmd      cmd;
    logic [IW-1:0]       in_row, in_col;
    logic [WW-1:0]       in_weight;
    logic                in_range;
    logic                s_fire, out_free, q_xfer, ack_load;
    apsp_pkg::t_host_req req;
    logic [WW-1:0]       eng_dist, q_dist;
    logic [XW-1:0]       eng_via, q_via;
    logic                q_reach;
    logic                eng_done;

    // input beat fields
    assign cmd       = apsp_pkg::t_cmd'(i_s_axis_tdata[1:0]);
    assign in_row    = i_s_axis_tdata[5:2];
    assign in_col    = i_s_axis_tdata[9:6];
    assign in_weight = i_s_axis_tdata[25:10];
    assign in_range  = (int'(in_row) < MAX_VERTICES) && (int'(in_col) < MAX_VERTICES);

    // handshake terms
    assign s_fire   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign q_xfer   = r_q_pend && out_free;
    assign ack_load = (r_state == apsp_pkg::TOP_ACK) && out_free;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= apsp_pkg::VC_RESET;
            r_no_edge      <= apsp_pkg::NO_EDGE_RESET;
        end else if (i_cfg_we) begin
            unique case (apsp_pkg::t_cfg_idx'(i_cfg_idx))
                apsp_pkg::CFG_VERTEX_COUNT: r_vertex_count <= i_cfg_data[apsp_pkg::VC_W-1:0];
                apsp_pkg::CFG_NO_EDGE:      r_no_edge      <= i_cfg_data[WW-1:0];
                default: ;
            endcase
        end
    end

    // command decode into the engine request
    always_comb begin
        req        = '0;
        req.row    = in_row;
        req.col    = in_col;
        req.weight = ((in_row != in_col) && (in_weight == '0)) ? r_no_edge : in_weight;
        if (s_fire) begin
            unique case (cmd)
                apsp_pkg::CMD_LOAD:  req.ld_en = in_range;
                apsp_pkg::CMD_RUN:   req.run   = 1'b1;
                apsp_pkg::CMD_QUERY: req.q_en  = in_range;
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            apsp_pkg::TOP_IDLE: if (req.run) n_state = apsp_pkg::TOP_RUN;
            apsp_pkg::TOP_RUN:  if (eng_done) n_state = apsp_pkg::TOP_ACK;
            apsp_pkg::TOP_ACK:  if (out_free) n_state = apsp_pkg::TOP_IDLE;
            default:            n_state = apsp_pkg::TOP_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_s_axis_tready = (r_state == apsp_pkg::TOP_IDLE) && (!r_q_pend || out_free);
        o_m_axis_tvalid = r_out_valid;
        o_m_axis_tdata  = r_out_data;
        o_m_axis_tuser  = r_out_user;
    end

    // query answer from the read stage
    assign q_dist  = r_q_oob ? r_no_edge : eng_dist;
    assign q_via   = r_q_oob ? '0 : eng_via;
    assign q_reach = (q_dist < r_no_edge);

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= apsp_pkg::TOP_IDLE;
            r_q_pend    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_fire && (cmd == apsp_pkg::CMD_QUERY)) begin
                r_q_pend <= 1'b1;
            end else if (q_xfer) begin
                r_q_pend <= 1'b0;
            end
            if (q_xfer || ack_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (s_fire && (cmd == apsp_pkg::CMD_QUERY)) begin
            r_q_oob <= !in_range;
        end
        if (q_xfer) begin
            r_out_data <= {2'b00, q_via, q_reach, q_dist};
            r_out_user <= 1'b1;
        end else if (ack_load) begin
            r_out_data <= '0;
            r_out_user <= 1'b0;
        end
    end

    apsp_engine #(.MAX_VERTICES(MAX_VERTICES)) u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (req),
        .i_vertex_count (r_vertex_count),
        .i_no_edge      (r_no_edge),
        .o_q_distance   (eng_dist),
        .o_q_via        (eng_via),
        .o_done         (eng_done)
    );

    // checks
    `APSP_ASSERT_IMPL(a_no_query_in_run, r_state != apsp_pkg::TOP_IDLE, !r_q_pend,
        "query pending during a run")
    `APSP_ASSERT_IMPL(a_done_in_run, eng_done, r_state == apsp_pkg::TOP_RUN,
        "engine done outside a run")
    `APSP_ASSERT_NEXT(a_ack_beat, ack_load, o_m_axis_tvalid && !o_m_axis_tuser[0],
        "run acknowledge not presented")

endmodule

FILE: hw/rtl/apsp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsp_ram
// Generic single-write, single-read memory with registered read data that
// holds while the read enable is low.
// ----------------------------------------------------------------------------
module apsp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/apsp_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apsp_engine
// Weight, distance and via memories with the run sequencer: a copy/clear
// sweep followed by the k, i, j relaxation loop as a read-modify-write pipe.
// ----------------------------------------------------------------------------
`include "all_pairs_shortest_path_assert.svh"

module apsp_engine #(
    parameter int MAX_VERTICES = apsp_pkg::DEF_MAX_VERTICES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  apsp_pkg::t_host_req           i_req,
    input  logic [apsp_pkg::VC_W-1:0]     i_vertex_count,
    input  logic [apsp_pkg::WEIGHT_W-1:0] i_no_edge,
    output logic [apsp_pkg::WEIGHT_W-1:0] o_q_distance,
    output logic [apsp_pkg::VIA_W-1:0]    o_q_via,
    output logic                          o_done
);

    localparam int VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int AW    = 2 * VW;
    localparam int DEPTH = 1 << AW;
    localparam int NW    = $clog2(MAX_VERTICES + 1);
    localparam int WW    = apsp_pkg::WEIGHT_W;
    localparam int XW    = apsp_pkg::VIA_W;

    apsp_pkg::t_eng_state r_state, n_state;

    logic [AW-1:0] r_sw_addr, n_sw_addr;
    logic          r_sw_valid;
    logic          r_sw_copy;
    logic [AW-1:0] r_sw_wr_addr;
    logic [VW-1:0] r_k, n_k;
    logic [VW-1:0] r_i, n_i;
    logic [VW-1:0] r_j, n_j;
    logic [WW-1:0] r_ik;
    logic          r_px_valid;
    logic [AW-1:0] r_px_addr;
    logic [XW-1:0] r_px_via;
    logic          r_fw_hit_a, r_fw_hit_b;
    logic [WW-1:0] r_fw_data_a, r_fw_data_b;

    logic [NW-1:0] n_act;
    logic [VW-1:0] n_last;
    logic          n_zero;
    logic [AW-1:0] host_addr;
    logic          last_i, last_j, last_pair, ik_ok;

    logic          w_wr_en, w_rd_en;
    logic [AW-1:0] w_rd_addr;
    logic [WW-1:0] w_rd_data;
    logic          d_wr_en;
    logic [AW-1:0] d_wr_addr;
    logic [WW-1:0] d_wr_data;
    logic          rd_en_a, rd_en_b;
    logic [AW-1:0] rd_addr_a, rd_addr_b;
    logic [WW-1:0] ram_q_a, ram_q_b, dist_a, dist_b;
    logic          v_wr_en;
    logic [AW-1:0] v_wr_addr;
    logic [XW-1:0] v_wr_data;
    logic [WW:0]   sum;
    logic          rx_wr;

    // active vertex count saturates at the built size
    always_comb begin
        if (int'(i_vertex_count) > MAX_VERTICES) begin
            n_act = NW'(MAX_VERTICES);
        end else begin
            n_act = NW'(i_vertex_count);
        end
    end

    assign n_last    = VW'(n_act - NW'(1));
    assign n_zero    = (n_act == '0);
    assign host_addr = {VW'(i_req.row), VW'(i_req.col)};
    assign last_i    = (r_i == n_last);
    assign last_j    = (r_j == n_last);
    assign last_pair = last_i && (r_k == n_last);
    assign ik_ok     = apsp_pkg::usable_leg(dist_a, i_no_edge);

    // forwarded read data covers a read and a write to one entry in one cycle
    assign dist_a = r_fw_hit_a ? r_fw_data_a : ram_q_a;
    assign dist_b = r_fw_hit_b ? r_fw_data_b : ram_q_b;

    // relaxation compare on the returning pair
    assign sum   = {1'b0, r_ik} + {1'b0, dist_b};
    assign rx_wr = r_px_valid && apsp_pkg::usable_leg(dist_b, i_no_edge)
                   && (sum < {1'b0, dist_a});

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            apsp_pkg::ENG_IDLE: begin
                if (i_req.run) n_state = apsp_pkg::ENG_SWEEP;
            end
            apsp_pkg::ENG_SWEEP: begin
                if (r_sw_addr == '1) n_state = apsp_pkg::ENG_SWEEP_TAIL;
            end
            apsp_pkg::ENG_SWEEP_TAIL: begin
                n_state = n_zero ? apsp_pkg::ENG_DONE : apsp_pkg::ENG_IK;
            end
            apsp_pkg::ENG_IK: begin
                n_state = apsp_pkg::ENG_IK_CHECK;
            end
            apsp_pkg::ENG_IK_CHECK: begin
                if (ik_ok) begin
                    n_state = apsp_pkg::ENG_ROW;
                end else begin
                    n_state = last_pair ? apsp_pkg::ENG_DONE : apsp_pkg::ENG_IK;
                end
            end
            apsp_pkg::ENG_ROW: begin
                if (last_j) n_state = last_pair ? apsp_pkg::ENG_DONE : apsp_pkg::ENG_IK;
            end
            apsp_pkg::ENG_DONE: begin
                n_state = apsp_pkg::ENG_IDLE;
            end
            default: n_state = apsp_pkg::ENG_IDLE;
        endcase
    end

    // loop counters
    always_comb begin
        n_sw_addr = r_sw_addr;
        n_k       = r_k;
        n_i       = r_i;
        n_j       = r_j;
        if (r_state == apsp_pkg::ENG_IDLE) begin
            n_sw_addr = '0;
        end
        if (r_state == apsp_pkg::ENG_SWEEP) begin
            n_sw_addr = r_sw_addr + AW'(1);
        end
        if (r_state == apsp_pkg::ENG_SWEEP_TAIL) begin
            n_k = '0;
            n_i = '0;
        end
        if (r_state == apsp_pkg::ENG_IK_CHECK && ik_ok) begin
            n_j = '0;
        end
        if (r_state == apsp_pkg::ENG_ROW) begin
            n_j = r_j + VW'(1);
        end
        // row finished or skipped: step i, then k
        if ((r_state == apsp_pkg::ENG_IK_CHECK && !ik_ok)
                || (r_state == apsp_pkg::ENG_ROW && last_j)) begin
            if (last_i) begin
                n_i = '0;
                n_k = r_k + VW'(1);
            end else begin
                n_i = r_i + VW'(1);
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= apsp_pkg::ENG_IDLE;
            r_sw_valid <= 1'b0;
            r_px_valid <= 1'b0;
            r_fw_hit_a <= 1'b0;
            r_fw_hit_b <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_sw_valid <= (r_state == apsp_pkg::ENG_SWEEP);
            r_px_valid <= (r_state == apsp_pkg::ENG_ROW);
            if (rd_en_a) r_fw_hit_a <= d_wr_en && (d_wr_addr == rd_addr_a);
            if (rd_en_b) r_fw_hit_b <= d_wr_en && (d_wr_addr == rd_addr_b);
        end
    end

    // counters and pipe payload
    always_ff @(posedge i_clk) begin
        r_sw_addr    <= n_sw_addr;
        r_k          <= n_k;
        r_i          <= n_i;
        r_j          <= n_j;
        r_sw_wr_addr <= r_sw_addr;
        r_sw_copy    <= (int'(r_sw_addr[AW-1:VW]) < int'(n_act))
                        && (int'(r_sw_addr[VW-1:0]) < int'(n_act));
        r_px_addr    <= {r_i, r_j};
        r_px_via     <= XW'(int'(r_k) + 1);
        if (r_state == apsp_pkg::ENG_IK_CHECK) r_ik <= dist_a;
        if (rd_en_a) r_fw_data_a <= d_wr_data;
        if (rd_en_b) r_fw_data_b <= d_wr_data;
    end

    // memory port selection and outputs
    always_comb begin
        w_wr_en   = i_req.ld_en;
        w_rd_en   = (r_state == apsp_pkg::ENG_SWEEP);
        w_rd_addr = r_sw_addr;

        d_wr_en   = (r_sw_valid && r_sw_copy) || rx_wr;
        d_wr_addr = r_sw_valid ? r_sw_wr_addr : r_px_addr;
        d_wr_data = r_sw_valid ? w_rd_data : sum[WW-1:0];

        v_wr_en   = r_sw_valid || rx_wr;
        v_wr_addr = r_sw_valid ? r_sw_wr_addr : r_px_addr;
        v_wr_data = r_sw_valid ? '0 : r_px_via;

        rd_en_a   = i_req.q_en || (r_state == apsp_pkg::ENG_IK)
                    || (r_state == apsp_pkg::ENG_ROW);
        unique case (r_state)
            apsp_pkg::ENG_IK:  rd_addr_a = {r_i, r_k};
            apsp_pkg::ENG_ROW: rd_addr_a = {r_i, r_j};
            default:           rd_addr_a = host_addr;
        endcase
        rd_en_b   = (r_state == apsp_pkg::ENG_ROW);
        rd_addr_b = {r_k, r_j};

        o_q_distance = dist_a;
        o_done       = (r_state == apsp_pkg::ENG_DONE);
    end

    // edge weights
    apsp_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_weight (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (host_addr),
        .i_wr_data (i_req.weight),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // distances, two copies written alike for two read ports
    apsp_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_dist_a (
        .i_clk     (i_clk),
        .i_wr_en   (d_wr_en),
        .i_wr_addr (d_wr_addr),
        .i_wr_data (d_wr_data),
        .i_rd_en   (rd_en_a),
        .i_rd_addr (rd_addr_a),
        .o_rd_data (ram_q_a)
    );

    apsp_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_dist_b (
        .i_clk     (i_clk),
        .i_wr_en   (d_wr_en),
        .i_wr_addr (d_wr_addr),
        .i_wr_data (d_wr_data),
        .i_rd_en   (rd_en_b),
        .i_rd_addr (rd_addr_b),
        .o_rd_data (ram_q_b)
    );

    // intermediate vertices
    apsp_ram #(.WIDTH(XW), .DEPTH(DEPTH)) u_via (
        .i_clk     (i_clk),
        .i_wr_en   (v_wr_en),
        .i_wr_addr (v_wr_addr),
        .i_wr_data (v_wr_data),
        .i_rd_en   (i_req.q_en),
        .i_rd_addr (host_addr),
        .o_rd_data (o_q_via)
    );

    // checks
    `APSP_ASSERT_IMPL(a_run_when_idle, i_req.run, r_state == apsp_pkg::ENG_IDLE,
        "run started while engine busy")
    `APSP_ASSERT_NEVER(a_write_overlap, r_sw_valid && r_px_valid,
        "sweep and relax writes overlap")
    `APSP_ASSERT_NEXT(a_done_pulse, o_done, !o_done, "done held longer than one cycle")

endmodule

FILE: tb/all_pairs_shortest_path_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_tb
// Drives edge loads, full runs and pair queries into the shortest path engine
// and checks every result beat against an in-bench Floyd-Warshall predictor
// or the fixed values of the directed script. Starts by filling the whole weight
// store, walks a short directed script, then runs random phases at different
// vertex counts and no-edge values with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module all_pairs_shortest_path_tb;

    localparam int NV            = apsp_pkg::DEF_MAX_VERTICES;
    localparam int ITEM_TARGET   = 1750;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 20000;
    localparam int PRESSURE_PHASE = 2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic        is_answer;
        logic [15:0] distance;
        logic        reach;
        logic [4:0]  via;
    } t_path_result;

    typedef struct {
        bit                 is_cfg;
        apsp_pkg::t_cfg_idx cfg_idx;
        logic [15:0]        cfg_val;
        logic [1:0]         cmd;
        logic [3:0]         row;
        logic [3:0]         col;
        logic [15:0]        weight;
        bit                 typed;
        t_path_result       want;
    } t_script_row;

    // dut signals
    logic                             clk = 1'b0;
    logic                             rst_n;
    logic [apsp_pkg::S_TDATA_W-1:0]   s_data;
    logic                             s_valid;
    logic                             s_ready;
    logic [apsp_pkg::M_TDATA_W-1:0]   m_data;
    logic [apsp_pkg::M_TUSER_W-1:0]   m_user;
    logic                             m_valid;
    logic                             m_ready;
    logic                             cfg_we;
    logic [apsp_pkg::CFG_IDX_W-1:0]   cfg_idx;
    logic [apsp_pkg::CFG_DATA_W-1:0]  cfg_data;

    // predictor state
    logic [15:0] wt_mem   [NV*NV];
    logic [15:0] dist_mem [NV*NV];
    logic [4:0]  via_mem  [NV*NV];
    logic [4:0]  vc_reg;
    logic [15:0] no_edge_reg;

    t_path_result pending_answers[$];
    t_path_result unused_result;
    t_script_row  script[$];

    bit gaps_on;
    bit hold_results;
    int n_loads, n_runs, n_queries, n_ignored, n_cfg, n_checked, n_err;

    always #4 clk = ~clk;

    all_pairs_shortest_path uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tdata  (s_data),     // command, row, col, weight
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .o_m_axis_tdata  (m_data),     // distance, reachable, via_vertex
        .o_m_axis_tuser  (m_user),     // is_query_answer
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------

    // a leg counts only when nonzero and below the no-edge value
    function automatic bit leg_ok(input logic [15:0] w);
        return (w != 16'd0) && (w < no_edge_reg);
    endfunction

    function automatic void relax_all_pairs();
        int n, i, j, k;
        logic [16:0] ik, kj, total;
        n = (vc_reg > NV) ? NV : int'(vc_reg);
        for (i = 0; i < NV*NV; i++) via_mem[i] = '0;
        for (i = 0; i < n; i++)
            for (j = 0; j < n; j++)
                dist_mem[i*NV+j] = wt_mem[i*NV+j];
        for (k = 0; k < n; k++) begin
            for (i = 0; i < n; i++) begin
                ik = {1'b0, dist_mem[i*NV+k]};
                if (leg_ok(ik[15:0])) begin
                    for (j = 0; j < n; j++) begin
                        kj = {1'b0, dist_mem[k*NV+j]};
                        if (leg_ok(kj[15:0])) begin
                            total = ik + kj;
                            if (total < {1'b0, dist_mem[i*NV+j]}) begin
                                dist_mem[i*NV+j] = total[15:0];
                                via_mem[i*NV+j]  = 5'(k + 1);
                            end
                        end
                    end
                end
            end
        end
    endfunction

    // one accepted command beat; returns 1 when it yields a result beat
    function automatic bit path_step(input logic [1:0] cmd, input logic [3:0] row,
                                     input logic [3:0] col, input logic [15:0] weight,
                                     output t_path_result res);
        int slot;
        slot = int'({row, col});
        res  = '0;
        case (cmd)
            apsp_pkg::CMD_LOAD: begin
                wt_mem[slot] = (row != col && weight == 16'd0) ? no_edge_reg : weight;
                n_loads++;
                return 1'b0;
            end
            apsp_pkg::CMD_RUN: begin
                relax_all_pairs();
                n_runs++;
                return 1'b1;
            end
            apsp_pkg::CMD_QUERY: begin
                res.is_answer = 1'b1;
                res.distance  = dist_mem[slot];
                res.reach     = dist_mem[slot] < no_edge_reg;
                res.via       = via_mem[slot];
                n_queries++;
                return 1'b1;
            end
            default: begin
                n_ignored++;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic t_path_result mk_result(input logic ans, input logic [15:0] distance,
                                               input logic reach, input logic [4:0] via);
        t_path_result r;
        r.is_answer = ans;
        r.distance  = distance;
        r.reach     = reach;
        r.via       = via;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // mostly short edges that can relax, plus no-edge, blocked and full-range values
    function automatic logic [15:0] rand_weight();
        int pick, lim;
        pick = $urandom_range(0, 99);
        lim  = (no_edge_reg > 3) ? int'(no_edge_reg) / 3 : 1;
        if (pick < 12) return 16'd0;
        if (pick < 22) return 16'($urandom);
        if (pick < 30) return 16'($urandom_range(int'(no_edge_reg), 65535));
        if (pick < 34) return 16'hFFFF;
        return 16'($urandom_range(1, lim));
    endfunction

    function automatic logic [3:0] pick_index(input int n_act);
        if (n_act > 0) return 4'($urandom_range(0, n_act - 1));
        return 4'($urandom_range(0, NV - 1));
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        n_err++;
    endtask

    // offer one command beat and record what it should produce
    task automatic send_beat(input logic [1:0] cmd, input logic [3:0] row,
                             input logic [3:0] col, input logic [15:0] weight,
                             input bit typed, input t_path_result want);
        int gap;
        bit gives;
        t_path_result pred;
        gap = gaps_on ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= {6'd0, weight, col, row, cmd};
        @(posedge clk);
        while (s_ready !== 1'b1) @(posedge clk);
        gives = path_step(cmd, row, col, weight, pred);
        if (gives) pending_answers.push_back(typed ? want : pred);
    endtask

    // drop valid, let all results drain and the load path go quiet
    task automatic settle_pipeline();
        s_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input apsp_pkg::t_cfg_idx idx, input logic [15:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        if (idx == apsp_pkg::CFG_VERTEX_COUNT) vc_reg = val[4:0];
        else no_edge_reg = val;
        n_cfg++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic add_cfg(input apsp_pkg::t_cfg_idx idx, input logic [15:0] val);
        t_script_row r;
        r         = '{cfg_idx: apsp_pkg::CFG_VERTEX_COUNT, default: '0};
        r.is_cfg  = 1'b1;
        r.cfg_idx = idx;
        r.cfg_val = val;
        script.push_back(r);
    endtask

    task automatic add_beat(input logic [1:0] cmd, input logic [3:0] row,
                            input logic [3:0] col, input logic [15:0] weight);
        t_script_row r;
        r        = '{cfg_idx: apsp_pkg::CFG_VERTEX_COUNT, default: '0};
        r.cmd    = cmd;
        r.row    = row;
        r.col    = col;
        r.weight = weight;
        script.push_back(r);
    endtask

    task automatic add_checked(input logic [1:0] cmd, input logic [3:0] row,
                               input logic [3:0] col, input t_path_result want);
        t_script_row r;
        r       = '{cfg_idx: apsp_pkg::CFG_VERTEX_COUNT, default: '0};
        r.cmd   = cmd;
        r.row   = row;
        r.col   = col;
        r.typed = 1'b1;
        r.want  = want;
        script.push_back(r);
    endtask

    // one random phase: new settings, a graph, a run, then a command mix
    task automatic run_phase(input int phase_no);
        int pick, n_act, len, r, c;
        logic [4:0]  vc_new;
        logic [15:0] ne_new;
        pick = $urandom_range(0, 99);
        if (pick < 55)      vc_new = 5'($urandom_range(1, 5));
        else if (pick < 80) vc_new = 5'($urandom_range(6, 10));
        else if (pick < 88) vc_new = 5'($urandom_range(11, 15));
        else if (pick < 93) vc_new = 5'd16;
        else if (pick < 97) vc_new = 5'($urandom_range(17, 31));
        else                vc_new = 5'd0;
        pick = $urandom_range(0, 99);
        if (pick < 40)      ne_new = 16'd1000;
        else if (pick < 60) ne_new = 16'($urandom_range(1, 65535));
        else if (pick < 75) ne_new = 16'($urandom_range(20, 200));
        else if (pick < 85) ne_new = 16'hFFFF;
        else if (pick < 92) ne_new = 16'd1;
        else                ne_new = 16'($urandom_range(2, 20));

        settle_pipeline();
        write_cfg(apsp_pkg::CFG_VERTEX_COUNT, {11'd0, vc_new});
        write_cfg(apsp_pkg::CFG_NO_EDGE, ne_new);
        gaps_on = ($urandom_range(0, 9) < 7);
        n_act   = (vc_new > NV) ? NV : int'(vc_new);

        // graph over the active block, sparse for the larger sizes
        for (r = 0; r < n_act; r++)
            for (c = 0; c < n_act; c++)
                if (n_act <= 6 || $urandom_range(0, 3) == 0)
                    send_beat(apsp_pkg::CMD_LOAD, 4'(r), 4'(c), rand_weight(), 1'b0,
                              unused_result);
        send_beat(apsp_pkg::CMD_RUN, 4'd0, 4'd0, 16'd0, 1'b0, unused_result);

        // back-to-back queries against a long result hold-off
        if (phase_no == PRESSURE_PHASE) begin
            gaps_on      = 1'b0;
            hold_results = 1'b1;
            repeat (24)
                send_beat(apsp_pkg::CMD_QUERY, pick_index(n_act), pick_index(n_act),
                          16'($urandom), 1'b0, unused_result);
        end

        len = $urandom_range(30, 60);
        repeat (len) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                send_beat(apsp_pkg::CMD_QUERY, pick_index(n_act), pick_index(n_act),
                          16'($urandom), 1'b0, unused_result);
            else if (pick < 72)
                send_beat(apsp_pkg::CMD_QUERY, 4'($urandom), 4'($urandom), 16'($urandom),
                          1'b0, unused_result);
            else if (pick < 84)
                send_beat(apsp_pkg::CMD_LOAD, pick_index(n_act), pick_index(n_act),
                          rand_weight(), 1'b0, unused_result);
            else if (pick < 88)
                send_beat(apsp_pkg::CMD_LOAD, 4'($urandom), 4'($urandom), rand_weight(),
                          1'b0, unused_result);
            else if (pick < 93)
                send_beat(apsp_pkg::CMD_RUN, 4'($urandom), 4'($urandom), 16'($urandom),
                          1'b0, unused_result);
            else
                send_beat(CMD_UNUSED, 4'($urandom), 4'($urandom), 16'($urandom),
                          1'b0, unused_result);
        end
    endtask

    // ------------------------------------------------------------------------
    // result side: random stalls, one long hold-off, field checks
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        t_path_result seen, want;
        m_ready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            if (hold_results) begin
                hold_results = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                stall = gaps_on ? $urandom_range(0, 13) : 0;
                if (stall > 0) begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            m_ready <= 1'b1;
            @(posedge clk);
            while (m_valid !== 1'b1) @(posedge clk);
            seen.is_answer = m_user[0];
            seen.distance  = m_data[15:0];
            seen.reach     = m_data[16];
            seen.via       = m_data[21:17];
            if (pending_answers.size() == 0) begin
                report_mismatch("result beat with nothing pending", 1, 0);
            end else begin
                want = pending_answers.pop_front();
                n_checked++;
                if (seen.is_answer !== want.is_answer)
                    report_mismatch("is_query_answer", seen.is_answer, want.is_answer);
                if (seen.distance !== want.distance)
                    report_mismatch("distance", seen.distance, want.distance);
                if (seen.reach !== want.reach)
                    report_mismatch("reachable", seen.reach, want.reach);
                if (seen.via !== want.via)
                    report_mismatch("via_vertex", seen.via, want.via);
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: too long without a beat on either side
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if (rst_n !== 1'b1 || (s_valid === 1'b1 && s_ready === 1'b1) ||
                (m_ready === 1'b1 && m_valid === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] watchdog: no beat for %0d cycles", $time, QUIET_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int slot, idx, phase_no;
        rst_n    <= 1'b0;
        s_valid  <= 1'b0;
        s_data   <= '0;
        cfg_we   <= 1'b0;
        cfg_idx  <= apsp_pkg::CFG_VERTEX_COUNT;
        cfg_data <= '0;
        vc_reg        = apsp_pkg::VC_RESET;
        no_edge_reg   = apsp_pkg::NO_EDGE_RESET;
        unused_result = '0;
        for (slot = 0; slot < NV*NV; slot++) begin
            wt_mem[slot]   = '0;
            dist_mem[slot] = '0;
            via_mem[slot]  = '0;
        end
        gaps_on      = 1'b1;
        hold_results = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every weight slot gets a value before any run reads it
        for (slot = 0; slot < NV*NV; slot++)
            send_beat(apsp_pkg::CMD_LOAD, slot[7:4], slot[3:0], rand_weight(), 1'b0,
                      unused_result);

        // directed script; the first run at full size defines every distance
        add_checked(apsp_pkg::CMD_RUN, 4'd0, 4'd0, mk_result(1'b0, 16'd0, 1'b0, 5'd0));
        add_beat(apsp_pkg::CMD_QUERY, 4'd15, 4'd15, 16'd0);
        add_cfg(apsp_pkg::CFG_VERTEX_COUNT, 16'd3);
        // 0 -> 1 -> 2 chain, all other pairs unconnected
        add_beat(apsp_pkg::CMD_LOAD, 4'd0, 4'd0, 16'd0);
        add_beat(apsp_pkg::CMD_LOAD, 4'd0, 4'd1, 16'd5);
        add_beat(apsp_pkg::CMD_LOAD, 4'd0, 4'd2, 16'd0);
        add_beat(apsp_pkg::CMD_LOAD, 4'd1, 4'd0, 16'd0);
        add_beat(apsp_pkg::CMD_LOAD, 4'd1, 4'd1, 16'd0);
        add_beat(apsp_pkg::CMD_LOAD, 4'd1, 4'd2, 16'd7);
        add_beat(apsp_pkg::CMD_LOAD, 4'd2, 4'd0, 16'd0);
        add_beat(apsp_pkg::CMD_LOAD, 4'd2, 4'd1, 16'd0);
        add_beat(apsp_pkg::CMD_LOAD, 4'd2, 4'd2, 16'd0);
        add_checked(apsp_pkg::CMD_RUN, 4'd0, 4'd0, mk_result(1'b0, 16'd0, 1'b0, 5'd0));
        add_checked(apsp_pkg::CMD_QUERY, 4'd0, 4'd2, mk_result(1'b1, 16'd12, 1'b1, 5'd2));
        add_checked(apsp_pkg::CMD_QUERY, 4'd2, 4'd0, mk_result(1'b1, 16'd1000, 1'b0, 5'd0));
        add_checked(apsp_pkg::CMD_QUERY, 4'd0, 4'd0, mk_result(1'b1, 16'd0, 1'b1, 5'd0));
        // pair beyond the vertex count keeps its older distance
        add_beat(apsp_pkg::CMD_QUERY, 4'd9, 4'd5, 16'd0);
        add_beat(CMD_UNUSED, 4'd15, 4'd15, 16'hFFFF);
        add_beat(apsp_pkg::CMD_LOAD, 4'd1, 4'd0, 16'hFFFF);
        // zero vertices: distances stay, via store is cleared
        add_cfg(apsp_pkg::CFG_VERTEX_COUNT, 16'd0);
        add_checked(apsp_pkg::CMD_RUN, 4'd0, 4'd0, mk_result(1'b0, 16'd0, 1'b0, 5'd0));
        add_checked(apsp_pkg::CMD_QUERY, 4'd0, 4'd2, mk_result(1'b1, 16'd12, 1'b1, 5'd0));
        // count above the built size saturates
        add_cfg(apsp_pkg::CFG_VERTEX_COUNT, 16'd31);
        add_checked(apsp_pkg::CMD_RUN, 4'd0, 4'd0, mk_result(1'b0, 16'd0, 1'b0, 5'd0));
        add_beat(apsp_pkg::CMD_QUERY, 4'd1, 4'd0, 16'd0);
        add_cfg(apsp_pkg::CFG_NO_EDGE, 16'd1);
        add_beat(apsp_pkg::CMD_QUERY, 4'd0, 4'd1, 16'd0);
        add_cfg(apsp_pkg::CFG_NO_EDGE, 16'hFFFF);
        add_checked(apsp_pkg::CMD_RUN, 4'd0, 4'd0, mk_result(1'b0, 16'd0, 1'b0, 5'd0));
        add_beat(apsp_pkg::CMD_QUERY, 4'd15, 4'd0, 16'd0);

        for (idx = 0; idx < script.size(); idx++) begin
            if (script[idx].is_cfg) begin
                settle_pipeline();
                write_cfg(script[idx].cfg_idx, script[idx].cfg_val);
            end else begin
                send_beat(script[idx].cmd, script[idx].row, script[idx].col,
                          script[idx].weight, script[idx].typed, script[idx].want);
            end
        end

        // random phases until the item budget is used up
        phase_no = 0;
        while (n_loads + n_runs + n_queries < ITEM_TARGET) begin
            run_phase(phase_no);
            phase_no++;
        end

        settle_pipeline();
        repeat (16) @(posedge clk);

        $display("covered %0d loads, %0d runs, %0d queries, %0d ignored beats, %0d reg writes",
                 n_loads, n_runs, n_queries, n_ignored, n_cfg);
        $display("%0d random phases, %0d result beats checked, %0d mismatches",
                 phase_no, n_checked, n_err);
        if (n_err == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
